// ===== rtl/bstk_pkg.sv =====
// Package for the bounded stack with search.
// Holds field widths, operation and status codes, and controller/datapath types.
// No dependencies.
`default_nettype none

package bstk_pkg;

  localparam int WORD_W    = 32;
  localparam int MODE_W    = 2;
  localparam int STAT_W    = 2;
  localparam int POS_W     = 6;
  localparam int FILL_W    = 7;
  localparam int DEPTH_DEF = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ADDR_TOP  = 2'd0,
    ADDR_ZERO = 2'd1,
    ADDR_NEXT = 2'd2
  } addr_sel_t;

  typedef enum logic [2:0] {
    RES_OK       = 3'd0,
    RES_OVERFLOW = 3'd1,
    RES_EMPTY    = 3'd2,
    RES_DATA     = 3'd3,
    RES_FOUND    = 3'd4,
    RES_NOTFOUND = 3'd5
  } res_kind_t;

  typedef struct packed {
    logic      ld_key;
    logic      push_wr;
    logic      pop_dec;
    addr_sel_t addr_sel;
    logic      scan_clr;
    logic      scan_inc;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bstk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bstk_ctrl.sv =====
// Controller for the bounded stack: sequences push, pop, peek and search.
// Depends on bstk_pkg.
`default_nettype none

module bstk_ctrl
  import bstk_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [MODE_W-1:0] mode,
  input  wire dp_stat_t          st,
  output cmd_t                   cmd,
  output logic                   busy,
  output logic                   done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN
  } state_t;

  state_t state, state_next;
  logic   done_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    done_next  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.ld_key = 1'b1;
          unique case (mode_t'(mode))
            MODE_PUSH: begin
              done_next    = 1'b1;
              cmd.res_load = 1'b1;
              if (st.full) begin
                cmd.res_kind = RES_OVERFLOW;
              end else begin
                cmd.push_wr  = 1'b1;
                cmd.res_kind = RES_OK;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (st.empty) begin
                done_next    = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_EMPTY;
              end else begin
                cmd.addr_sel = ADDR_TOP;
                cmd.pop_dec  = (mode_t'(mode) == MODE_POP);
                state_next   = S_READ;
              end
            end
            MODE_SEARCH: begin
              if (st.empty) begin
                done_next    = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_NOTFOUND;
              end else begin
                cmd.addr_sel = ADDR_ZERO;
                cmd.scan_clr = 1'b1;
                state_next   = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        done_next    = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_kind = RES_DATA;
        state_next   = S_IDLE;
      end
      S_SCAN: begin
        priority if (st.match) begin
          done_next    = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_FOUND;
          state_next   = S_IDLE;
        end else if (st.last) begin
          done_next    = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_NOTFOUND;
          state_next   = S_IDLE;
        end else begin
          cmd.addr_sel = ADDR_NEXT;
          cmd.scan_inc = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/bstk_dp.sv =====
// Datapath for the bounded stack: fill count, search key, scan pointer,
// result registers and the entry RAM.
// Depends on bstk_pkg and bstk_ram.
`default_nettype none

module bstk_dp
  import bstk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  input  wire logic signed [WORD_W-1:0] value,
  output dp_stat_t                      st,
  output logic [STAT_W-1:0]             status,
  output logic signed [WORD_W-1:0]      data,
  output logic [POS_W-1:0]              position,
  output logic [FILL_W-1:0]             fill_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]     count;
  logic [WORD_W-1:0] key;
  logic [AW-1:0]     cptr;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;
  logic [AW-1:0]     top_addr;

  assign top_addr = AW'(count - CW'(1));

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_TOP:  raddr = top_addr;
      ADDR_ZERO: raddr = '0;
      ADDR_NEXT: raddr = cptr + AW'(1);
      default:   raddr = '0;
    endcase
  end

  bstk_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push_wr),
    .waddr (AW'(count)),
    .wdata (value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign st.full  = (count == CW'(DEPTH));
  assign st.empty = (count == '0);
  assign st.match = (rdata == key);
  assign st.last  = ((CW'(cptr) + CW'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.push_wr) begin
      count <= count + CW'(1);
    end else if (cmd.pop_dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_key) begin
      key <= value;
    end
    if (cmd.scan_clr) begin
      cptr <= '0;
    end else if (cmd.scan_inc) begin
      cptr <= cptr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      data     <= '0;
      position <= '0;
      unique case (cmd.res_kind)
        RES_OK:       status <= ST_OK;
        RES_OVERFLOW: status <= ST_OVERFLOW;
        RES_EMPTY:    status <= ST_EMPTY;
        RES_DATA: begin
          status <= ST_OK;
          data   <= rdata;
        end
        RES_FOUND: begin
          status   <= ST_OK;
          position <= POS_W'(cptr);
        end
        RES_NOTFOUND: status <= ST_NOT_FOUND;
        default:      status <= ST_OK;
      endcase
    end
  end

  assign fill_count = FILL_W'(count);

endmodule

`default_nettype wire

// ===== rtl/bounded_stack_with_search.sv =====
// Bounded last-in-first-out stack of signed 32-bit words with a linear search.
// Top level: joins bstk_ctrl and bstk_dp; depends on bstk_pkg.
//
// A word is taken when start is high and busy is low; its result appears on
// status, data, position and fill_count for one cycle with done high, and
// cannot be held off. Push, including one on a full stack, and pop, peek or
// search on an empty stack give done in the cycle after acceptance with busy
// staying low, so a new word may be started in the done cycle. Pop and peek
// on a stack that holds entries keep busy high for one cycle, in S_READ, while
// the entry RAM is read, and give done after S_READ. Search compares one stored
// entry per cycle from the bottom through the single RAM read port: with k
// entries compared (k up to the fill count, at most DEPTH), busy stays high in
// S_SCAN while they are compared, and done follows the last compare.
// fill_count is the count after the operation.
`default_nettype none

module bounded_stack_with_search
  import bstk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [MODE_W-1:0]        mode,
  input  wire logic signed [WORD_W-1:0] value,
  output logic                          done,
  output logic [STAT_W-1:0]             status,
  output logic signed [WORD_W-1:0]      data,
  output logic [POS_W-1:0]              position,
  output logic [FILL_W-1:0]             fill_count
);

  cmd_t     cmd;
  dp_stat_t st;

  bstk_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bstk_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value      (value),
    .st         (st),
    .status     (status),
    .data       (data),
    .position   (position),
    .fill_count (fill_count)
  );

endmodule

`default_nettype wire

// ===== rtl/bstk_checker.sv =====
// Port-level checks for the bounded stack, attached to the top level by bind.
// Depends on bstk_pkg and bounded_stack_with_search.
`default_nettype none

module bstk_checker
  import bstk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     done,
  input wire logic [STAT_W-1:0]        status,
  input wire logic signed [WORD_W-1:0] data,
  input wire logic [POS_W-1:0]         position,
  input wire logic [FILL_W-1:0]        fill_count
);

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without an accepted word");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OVERFLOW) |-> (fill_count == FILL_W'(DEPTH) && data == '0))
    else $error("overflow reported on a stack that is not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (fill_count == '0 && data == '0 && position == '0))
    else $error("empty status with nonzero fields");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_NOT_FOUND) |-> (data == '0 && position == '0))
    else $error("not-found status with nonzero fields");

endmodule

bind bounded_stack_with_search bstk_checker #(.DEPTH(DEPTH)) u_bstk_checker (.*);

`default_nettype wire

// ===== test/tb_bounded_stack_with_search.sv =====
// Self-checking testbench for bounded_stack_with_search: directed and random words
// drive push/pop/peek/search, and a shadow stack predicts every result.
// Depends on bstk_pkg and the bounded_stack_with_search RTL.
`timescale 1ns / 1ps

module tb_bounded_stack_with_search;
  import bstk_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  typedef struct {
    status_t                    st;
    logic signed [WORD_W-1:0]   word;
    logic [POS_W-1:0]           pos;
    logic [FILL_W-1:0]          fill;
  } stack_reply_t;

  class stack_shadow;
    logic signed [WORD_W-1:0] words[DEPTH];
    int unsigned              count;
    stack_reply_t             owed_replies[$];
    int unsigned              errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function int unsigned held();
      return count;
    endfunction

    function logic signed [WORD_W-1:0] word_at(int unsigned idx);
      return words[idx];
    endfunction

    function int unsigned owed();
      return owed_replies.size();
    endfunction

    function void note_word(mode_t m, logic signed [WORD_W-1:0] v);
      stack_reply_t r;
      r.st = ST_OK;
      r.word = '0;
      r.pos = '0;
      case (m)
        MODE_PUSH: begin
          if (count >= DEPTH) begin
            r.st = ST_OVERFLOW;
          end else begin
            words[count] = v;
            count++;
          end
        end
        MODE_POP: begin
          if (count == 0) begin
            r.st = ST_EMPTY;
          end else begin
            count--;
            r.word = words[count];
          end
        end
        MODE_PEEK: begin
          if (count == 0) r.st = ST_EMPTY;
          else r.word = words[count-1];
        end
        default: begin
          r.st = ST_NOT_FOUND;
          for (int unsigned i = 0; i < count; i++) begin
            if (words[i] == v) begin
              r.st = ST_OK;
              r.pos = POS_W'(i);
              break;
            end
          end
        end
      endcase
      r.fill = FILL_W'(count);
      owed_replies.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic signed [WORD_W-1:0] d,
                               logic [POS_W-1:0] p, logic [FILL_W-1:0] f);
      stack_reply_t r;
      if (owed_replies.size() == 0) begin
        $error("result with none expected: status %0d data %0d", st, d);
        errors++;
        return;
      end
      r = owed_replies.pop_front();
      if (st !== r.st) begin
        $error("status: expected %0d, got %0d", r.st, st);
        errors++;
      end
      if (d !== r.word) begin
        $error("data: expected %0d, got %0d", r.word, d);
        errors++;
      end
      if (p !== r.pos) begin
        $error("position: expected %0d, got %0d", r.pos, p);
        errors++;
      end
      if (f !== r.fill) begin
        $error("fill_count: expected %0d, got %0d", r.fill, f);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [MODE_W-1:0]        mode = MODE_PUSH;
  logic signed [WORD_W-1:0] value = '0;
  logic                     busy;
  logic                     done;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] data;
  logic [POS_W-1:0]         position;
  logic [FILL_W-1:0]        fill_count;

  stack_shadow shadow = new();

  bounded_stack_with_search #(.DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .value(value),
    .done(done),
    .status(status),
    .data(data),
    .position(position),
    .fill_count(fill_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) shadow.check_result(status, data, position, fill_count);
  end

  task automatic send_word(input mode_t m, input logic signed [WORD_W-1:0] v,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.note_word(m, v);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (shadow.owed() != 0) @(posedge clk);
  endtask

  function automatic int pick_gap(bit idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 6) return $signed($urandom_range(0, 7)) - 3;
    if (r == 6) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    if (shadow.held() > 0) return shadow.word_at($urandom_range(0, shadow.held() - 1));
    return $urandom;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_key();
    int r;
    logic signed [WORD_W-1:0] w;
    r = $urandom_range(0, 99);
    if (shadow.held() == 0 || r >= 65) return pick_value();
    w = shadow.word_at($urandom_range(0, shadow.held() - 1));
    if (r >= 50) w = w ^ (32'sh1 << $urandom_range(0, WORD_W - 1));
    return w;
  endfunction

  // push/pop/peek weights per phase kind; the rest is search
  task automatic random_phase(input int items, input int kind, input bit idle_on);
    int push_w;
    int pop_w;
    int peek_w;
    int r;
    case (kind)
      0: begin push_w = 70; pop_w = 10; peek_w = 5; end
      1: begin push_w = 30; pop_w = 30; peek_w = 15; end
      default: begin push_w = 10; pop_w = 65; peek_w = 10; end
    endcase
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_w)
        send_word(MODE_PUSH, pick_value(), pick_gap(idle_on));
      else if (r < push_w + pop_w)
        send_word(MODE_POP, $urandom, pick_gap(idle_on));
      else if (r < push_w + pop_w + peek_w)
        send_word(MODE_PEEK, $urandom, pick_gap(idle_on));
      else
        send_word(MODE_SEARCH, pick_key(), pick_gap(idle_on));
    end
  endtask

  initial begin
    int sent;
    int len;
    int phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty stack, extremes, duplicates, one-bit miss, drain to empty
    send_word(MODE_POP, 32'sh12345678, 0);
    send_word(MODE_PEEK, -1, 0);
    send_word(MODE_SEARCH, 0, 1);
    send_word(MODE_PUSH, 32'sh7fffffff, 0);
    send_word(MODE_PUSH, 32'sh80000000, 0);
    send_word(MODE_PUSH, 0, 2);
    send_word(MODE_PUSH, -1, 0);
    send_word(MODE_PUSH, 32'sh80000000, 0);
    send_word(MODE_PEEK, 0, 0);
    send_word(MODE_SEARCH, 32'sh80000000, 0);
    send_word(MODE_SEARCH, 32'sh80000001, 3);
    send_word(MODE_SEARCH, -1, 0);
    send_word(MODE_SEARCH, 32'sh7fffffff, 0);
    send_word(MODE_POP, 0, 0);
    send_word(MODE_POP, 0, 0);
    send_word(MODE_PEEK, 0, 1);
    send_word(MODE_SEARCH, 32'sh80000000, 0);
    send_word(MODE_POP, 0, 0);
    send_word(MODE_POP, 0, 0);
    send_word(MODE_POP, 0, 0);
    send_word(MODE_POP, 0, 0);
    send_word(MODE_SEARCH, -1, 0);
    drain();

    sent = 0;
    phase = 0;
    while (sent < 1400) begin
      len = $urandom_range(40, 120);
      random_phase(len, phase % 3, $urandom_range(0, 3) != 0);
      sent += len;
      phase++;
      if (phase % 4 == 0) drain();
    end

    drain();
    repeat (80) @(posedge clk);
    if (shadow.owed() != 0) begin
      $error("%0d results never arrived", shadow.owed());
      shadow.errors++;
    end
    if (shadow.errors == 0) begin
      $display("bounded_stack_with_search verification clean");
    end else begin
      $display("bounded_stack_with_search verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("bounded_stack_with_search verification failed");
    $finish;
  end

endmodule
